@@ rtl/core/block_gradient_orientation_assert.svh @@
// ----------------------------------------------------------------------------
// block_gradient_orientation assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef BLOCK_GRADIENT_ORIENTATION_ASSERT_SVH
`define BLOCK_GRADIENT_ORIENTATION_ASSERT_SVH

`ifndef SYNTHESIS

// condition must never hold
`define BGO_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("bgo: forbidden condition seen");

// consequent must hold in the same cycle as the antecedent
`define BGO_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bgo: same-cycle implication failed");

// consequent must hold in the cycle after the antecedent
`define BGO_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bgo: next-cycle implication failed");

`else

`define BGO_ASSERT_NEVER(lbl, expr)
`define BGO_ASSERT_IMP(lbl, ante, cons)
`define BGO_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

@@ rtl/core/bgo_pkg.sv @@
// ----------------------------------------------------------------------------
// bgo_pkg
// shared types and constants of the block gradient orientation core
// ----------------------------------------------------------------------------
package bgo_pkg;

  localparam int GRAD_W      = 11;   // signed sobel gradient
  localparam int PROD_W      = 22;   // signed product of two gradients
  localparam int ACC_W       = 34;   // energy accumulators, wrap modulo 2^34
  localparam int CX_W        = 44;   // cordic x/y working width
  localparam int NORM_BIT    = 40;   // normalised magnitude has this bit set
  localparam int ANG_W       = 29;   // signed angle, 2^-20 degree units
  localparam int SUM_W       = 30;   // angle plus half turn
  localparam int DEG_FRAC    = 20;
  localparam int DEG_W       = 8;
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W      = $clog2(CORDIC_STEPS);
  localparam int ATAN_W      = 26;

  localparam logic signed [ANG_W-1:0] DEG45  = ANG_W'(47185920);
  localparam logic signed [ANG_W-1:0] DEG90  = ANG_W'(94371840);
  localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(188743680);
  localparam logic [DEG_W-1:0]        DEG_MAX = DEG_W'(180);

  typedef logic [STEP_W-1:0] step_idx_t;

  // controller to datapath
  typedef struct packed {
    logic      accept;   // item taken this cycle
    logic      load;     // fold sums into first octant, clear accumulators
    logic      norm;     // one normalising shift
    logic      step;     // one cordic micro-rotation
    step_idx_t idx;      // micro-rotation index
    logic      finish;   // clamp and unfold the octant angle
    logic      emit;     // write the result register
  } bgo_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic special;       // exact angle known, no rotation needed
    logic norm_done;     // magnitude has reached the normalised range
  } bgo_status_t;

  // round(atan(2^-i) in degrees * 2^20)
  function automatic logic [ATAN_W-1:0] bgo_atan(input step_idx_t idx);
    logic [ATAN_W-1:0] val;
    case (idx)
      5'd0:    val = ATAN_W'(47185920);
      5'd1:    val = ATAN_W'(27855475);
      5'd2:    val = ATAN_W'(14718068);
      5'd3:    val = ATAN_W'(7471121);
      5'd4:    val = ATAN_W'(3750058);
      5'd5:    val = ATAN_W'(1876857);
      5'd6:    val = ATAN_W'(938658);
      5'd7:    val = ATAN_W'(469357);
      5'd8:    val = ATAN_W'(234682);
      5'd9:    val = ATAN_W'(117342);
      5'd10:   val = ATAN_W'(58671);
      5'd11:   val = ATAN_W'(29335);
      5'd12:   val = ATAN_W'(14668);
      5'd13:   val = ATAN_W'(7334);
      5'd14:   val = ATAN_W'(3667);
      5'd15:   val = ATAN_W'(1833);
      5'd16:   val = ATAN_W'(917);
      5'd17:   val = ATAN_W'(458);
      5'd18:   val = ATAN_W'(229);
      5'd19:   val = ATAN_W'(115);
      5'd20:   val = ATAN_W'(57);
      5'd21:   val = ATAN_W'(29);
      5'd22:   val = ATAN_W'(14);
      5'd23:   val = ATAN_W'(7);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

@@ rtl/core/block_gradient_orientation.sv @@
// ----------------------------------------------------------------------------
// block_gradient_orientation
// throughput: one pixel per cycle inside a block; after the last pixel the
//   input pauses until the result is in the output register
// processing: after the last pixel the sums pass the normalising shifter
//   and the 24-step shared cordic; both are skipped when the sums give an
//   exact angle (zero, axis or diagonal); the result is held back while the
//   previous result still waits in the output register
// reset: synchronous rst_n clears both energy sums, sequencer and valid flag
// ----------------------------------------------------------------------------
`include "block_gradient_orientation_assert.svh"

module block_gradient_orientation import bgo_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // pixel gradients
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [10:0] grad_x, [21:11] grad_y, [23:22] zero
  input  logic        in_tlast,   // block_last
  // block orientation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [7:0] orientation_deg
);

  bgo_cmd_t    cmd;
  bgo_status_t status;

  // sequencer: keeps ready high while a block streams in, drops it from
  // the last pixel until the result has been placed in the output register
  bgo_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // products are registered ahead of the 34-bit sums; the
  // cordic and output register sit behind the accumulators, and a result
  // still waiting in the output register holds the sequencer in its emit
  // state with the input closed
  bgo_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .grad_x          ($signed(in_tdata[GRAD_W-1:0])),
    .grad_y          ($signed(in_tdata[2*GRAD_W-1:GRAD_W])),
    .status          (status),
    .orientation_deg (out_tdata)
  );

  // no pixel is taken while the angle is being worked out
  `BGO_ASSERT_NEVER(a_no_accept_busy, in_tready && (cmd.load || cmd.norm || cmd.step))
  // the result register is written only when its item has gone or is going
  `BGO_ASSERT_IMP(a_emit_slot_free, cmd.emit, !out_tvalid || out_tready)
  // a taken last pixel closes the input until the result is out
  `BGO_ASSERT_NXT(a_last_closes_input, in_tvalid && in_tready && in_tlast, !in_tready)
  // orientation never leaves the half turn
  `BGO_ASSERT_IMP(a_result_range, out_tvalid, out_tdata <= DEG_MAX)

endmodule

@@ rtl/core/bgo_datapath.sv @@
// ----------------------------------------------------------------------------
// bgo_datapath
// gradient products, energy accumulators, normaliser, cordic and result
// ----------------------------------------------------------------------------
module bgo_datapath import bgo_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  bgo_cmd_t                 cmd,
  input  logic signed [GRAD_W-1:0] grad_x,
  input  logic signed [GRAD_W-1:0] grad_y,
  output bgo_status_t              status,
  output logic [DEG_W-1:0]         orientation_deg
);

  // product stage
  logic signed [PROD_W-1:0] sq_x_c, sq_y_c, xy_c;
  logic signed [PROD_W-1:0] sq_x_r, sq_y_r, xy_r;
  logic                     prod_vld_r;

  assign sq_x_c = PROD_W'(grad_x) * PROD_W'(grad_x);
  assign sq_y_c = PROD_W'(grad_y) * PROD_W'(grad_y);
  assign xy_c   = PROD_W'(grad_x) * PROD_W'(grad_y);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sq_x_r <= sq_x_c;
      sq_y_r <= sq_y_c;
      xy_r   <= xy_c;
    end
  end

  // accumulators
  logic signed [ACC_W-1:0] diff_r, cross_r;
  logic signed [ACC_W-1:0] diff_nxt, cross_nxt;

  assign diff_nxt  = diff_r + {{(ACC_W-PROD_W){sq_x_r[PROD_W-1]}}, sq_x_r}
                            - {{(ACC_W-PROD_W){sq_y_r[PROD_W-1]}}, sq_y_r};
  assign cross_nxt = cross_r + {{(ACC_W-PROD_W-1){xy_r[PROD_W-1]}}, xy_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      diff_r     <= '0;
      cross_r    <= '0;
    end else begin
      prod_vld_r <= cmd.accept;
      if (cmd.load) begin
        diff_r  <= '0;
        cross_r <= '0;
      end else if (prod_vld_r) begin
        diff_r  <= diff_nxt;
        cross_r <= cross_nxt;
      end
    end
  end

  // octant fold
  logic [ACC_W-1:0] ax_abs, ay_abs, big_c, small_c;
  logic             swap_c, special_c;

  assign ax_abs    = cross_r[ACC_W-1] ? ACC_W'(-cross_r) : ACC_W'(cross_r);
  assign ay_abs    = diff_r[ACC_W-1]  ? ACC_W'(-diff_r)  : ACC_W'(diff_r);
  assign swap_c    = ay_abs > ax_abs;
  assign big_c     = swap_c ? ay_abs : ax_abs;
  assign small_c   = swap_c ? ax_abs : ay_abs;
  assign special_c = (small_c == '0) || (small_c == big_c);

  // cordic
  logic signed [CX_W-1:0]  cx_r, cy_r, xs_c, ys_c;
  logic signed [ANG_W-1:0] z_r, atan_c;
  logic                    swap_r, xneg_r, yneg_r, special_r;

  assign xs_c   = cx_r >>> cmd.idx;
  assign ys_c   = cy_r >>> cmd.idx;
  assign atan_c = $signed({{(ANG_W-ATAN_W){1'b0}}, bgo_atan(cmd.idx)});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r      <= {{(CX_W-ACC_W){1'b0}}, big_c};
      cy_r      <= {{(CX_W-ACC_W){1'b0}}, small_c};
      z_r       <= (special_c && small_c != '0) ? DEG45 : '0;
      swap_r    <= swap_c;
      xneg_r    <= cross_r[ACC_W-1];
      yneg_r    <= diff_r[ACC_W-1];
      special_r <= special_c;
    end else if (cmd.norm) begin
      // coarse shift while far below range, then bit by bit
      if (cx_r[NORM_BIT:NORM_BIT-8] == '0) begin
        cx_r <= cx_r << 8;
        cy_r <= cy_r << 8;
      end else begin
        cx_r <= cx_r << 1;
        cy_r <= cy_r << 1;
      end
    end else if (cmd.step) begin
      if (!cy_r[CX_W-1]) begin
        cx_r <= cx_r + ys_c;
        cy_r <= cy_r - xs_c;
        z_r  <= z_r + atan_c;
      end else begin
        cx_r <= cx_r - ys_c;
        cy_r <= cy_r + xs_c;
        z_r  <= z_r - atan_c;
      end
    end
  end

  assign status.special   = special_r;
  assign status.norm_done = cx_r[NORM_BIT];

  // clamp and unfold
  logic signed [ANG_W-1:0] zc_c, a1_c, a2_c, a3_c, ang_r;

  always_comb begin
    if (z_r < 0) begin
      zc_c = '0;
    end else if (z_r > DEG45) begin
      zc_c = DEG45;
    end else begin
      zc_c = z_r;
    end
    a1_c = swap_r ? DEG90 - zc_c : zc_c;
    a2_c = xneg_r ? DEG180 - a1_c : a1_c;
    a3_c = yneg_r ? -a2_c : a2_c;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      ang_r <= a3_c;
    end
  end

  // half of (angle + 180 degrees) in whole degrees
  logic signed [SUM_W-1:0] s_c;
  logic [SUM_W-1:0]        s_pos_c;
  logic [SUM_W-DEG_FRAC-2:0] deg_c;
  logic [DEG_W-1:0]        out_r;

  assign s_c     = {ang_r[ANG_W-1], ang_r} + {1'b0, DEG180};
  assign s_pos_c = s_c[SUM_W-1] ? '0 : SUM_W'(s_c);
  assign deg_c   = s_pos_c[SUM_W-1:DEG_FRAC+1];

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= (deg_c > {1'b0, DEG_MAX}) ? DEG_MAX : deg_c[DEG_W-1:0];
    end
  end

  assign orientation_deg = out_r;

endmodule

@@ rtl/core/bgo_ctrl.sv @@
// ----------------------------------------------------------------------------
// bgo_ctrl
// sequencer for accumulate, fold, normalise, rotate and emit
// ----------------------------------------------------------------------------
module bgo_ctrl import bgo_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tlast,
  output logic        in_tready,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  bgo_status_t status,
  output bgo_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_RUN,
    S_DRAIN,
    S_LOAD,
    S_NORM,
    S_CORDIC,
    S_FIN,
    S_EMIT
  } state_t;

  state_t    state_r, state_nxt;
  step_idx_t cnt_r, cnt_nxt;
  logic      in_tready_r, in_tready_nxt;
  logic      out_valid_r, out_valid_nxt;
  logic      accept;

  assign accept = in_tvalid && in_tready_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    in_tready_nxt = in_tready_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.accept    = accept;
    cmd.idx       = cnt_r;
    case (state_r)
      S_RUN: begin
        if (accept && in_tlast) begin
          state_nxt     = S_DRAIN;
          in_tready_nxt = 1'b0;
        end
      end
      S_DRAIN: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        if (status.special) begin
          state_nxt = S_FIN;
        end else if (status.norm_done) begin
          state_nxt = S_CORDIC;
          cnt_nxt   = '0;
        end else begin
          cmd.norm = 1'b1;
        end
      end
      S_CORDIC: begin
        cmd.step = 1'b1;
        if (cnt_r == STEP_W'(CORDIC_STEPS - 1)) begin
          state_nxt = S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          in_tready_nxt = 1'b1;
          state_nxt     = S_RUN;
        end
      end
      default: begin
        state_nxt     = S_RUN;
        in_tready_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_RUN;
      cnt_r       <= '0;
      in_tready_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      in_tready_r <= in_tready_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_valid_r;

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: block_gradient_orientation bench
// streams blocks of signed gradient pixels through the core, predicts each
// block orientation with a local least-squares accumulator and cordic atan2,
// and checks every orientation item in order against the prediction
// ----------------------------------------------------------------------------
module tb_top;
  import bgo_pkg::*;

  localparam int  BLOCK_PIXELS   = 16 * 16;  // nominal block, 16 x 16 pixels
  localparam int  RANDOM_PIXELS  = 1520;
  localparam int  LONG_PIXELS    = 256;      // one block of nominal size
  localparam int  FRAC           = 20;       // angle units of 2^-20 degree
  localparam int  NORM_SHIFT_BIT = 40;
  localparam int  STEPS          = 24;
  localparam int  SETTLE_CYCLES  = 60;       // beyond the worst-case latency
  localparam int  REPORT_LIMIT   = 10;
  localparam int  CALM_FROM      = 1500;     // cycle window without idling
  localparam int  CALM_TO        = 3000;

  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic                     last;
  } pixel_t;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;   // [10:0] grad_x, [21:11] grad_y, [23:22] zero
  logic        in_tlast   = 1'b0; // block_last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;         // [7:0] orientation_deg

  block_gradient_orientation uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // round(atan(2^-i) in degrees * 2^20)
  longint arctan_lut [0:STEPS-1] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
    938658, 469357, 234682, 117342, 58671, 29335,
    14668, 7334, 3667, 1833, 917, 458,
    229, 115, 57, 29, 14, 7
  };

  pixel_t                   pixel_queue [$];
  logic [DEG_W-1:0]         orient_due [$];
  logic signed [ACC_W-1:0]  diff_acc  = '0;
  logic signed [ACC_W-1:0]  cross_acc = '0;
  longint                   gx_now, gy_now;
  logic                     in_taken = 1'b0;
  int                       mismatches = 0;
  int                       cycle = 0;
  logic                     calm;

  assign calm = (cycle >= CALM_FROM) && (cycle < CALM_TO);

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // predictor: 0.5 * (atan2(diff, cross) + 180) truncated to whole degrees
  // ---------------------------------------------------------------------------
  function automatic logic [DEG_W-1:0] orientation_of(longint diff, longint cross_sum);
    longint ax, ay, swap_tmp, x, y, z, xs, ys, ang, half;
    bit     swapped;
    swapped = 1'b0;
    ax = (cross_sum < 0) ? -cross_sum : cross_sum;
    ay = (diff < 0) ? -diff : diff;
    if (ax == 0 && ay == 0) begin
      ang = 0;
    end else begin
      if (ay > ax) begin
        swap_tmp = ax;
        ax = ay;
        ay = swap_tmp;
        swapped = 1'b1;
      end
      if (ay == 0) begin
        ang = 0;
      end else if (ay == ax) begin
        ang = longint'(45) << FRAC;
      end else begin
        // normalise, then vectoring micro-rotations with floor shifts
        while (ax < (longint'(1) << NORM_SHIFT_BIT)) begin
          ax = ax << 1;
          ay = ay << 1;
        end
        x = ax;
        y = ay;
        z = 0;
        for (int i = 0; i < STEPS; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + arctan_lut[i];
          end else begin
            x = x - ys;
            y = y + xs;
            z = z - arctan_lut[i];
          end
        end
        if (z < 0) z = 0;
        if (z > (longint'(45) << FRAC)) z = longint'(45) << FRAC;
        ang = z;
      end
      // unfold the octant angle
      if (swapped) ang = (longint'(90) << FRAC) - ang;
      if (cross_sum < 0) ang = (longint'(180) << FRAC) - ang;
      if (diff < 0) ang = -ang;
    end
    half = ang + (longint'(180) << FRAC);
    if (half < 0) half = 0;
    half = half >>> (FRAC + 1);
    if (half > 180) half = 180;
    return DEG_W'(half);
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------
  task automatic push_pixel(int gx, int gy, bit last);
    pixel_t p;
    p.gx   = GRAD_W'(gx);
    p.gy   = GRAD_W'(gy);
    p.last = last;
    pixel_queue.push_back(p);
  endtask

  function automatic int extreme_grad();
    int v;
    case ($urandom_range(0, 7))
      0: v = -1024;
      1: v = -1023;
      2: v = -1020;
      3: v = -1;
      4: v = 0;
      5: v = 1;
      6: v = 1020;
      default: v = 1023;
    endcase
    return v;
  endfunction

  // content styles: full 11-bit noise, extremes, tiny values, or a dominant
  // ridge direction with noise and random sign per pixel
  task automatic add_block(int len, int style);
    int bx, by, sgn, gx, gy;
    bx = $urandom_range(0, 400) - 200;
    by = $urandom_range(0, 400) - 200;
    for (int i = 0; i < len; i++) begin
      case (style)
        0: begin
          gx = $urandom_range(0, 2047) - 1024;
          gy = $urandom_range(0, 2047) - 1024;
        end
        1: begin
          gx = extreme_grad();
          gy = extreme_grad();
        end
        2: begin
          gx = $urandom_range(0, 16) - 8;
          gy = $urandom_range(0, 16) - 8;
        end
        default: begin
          sgn = $urandom_range(0, 1) ? 1 : -1;
          gx = sgn * bx * ($urandom_range(1, 5)) + $urandom_range(0, 40) - 20;
          gy = sgn * by * ($urandom_range(1, 5)) + $urandom_range(0, 40) - 20;
          if (gx > 1023) gx = 1023;
          if (gx < -1024) gx = -1024;
          if (gy > 1023) gy = 1023;
          if (gy < -1024) gy = -1024;
        end
      endcase
      push_pixel(gx, gy, i == len - 1);
    end
  endtask

  initial begin
    int random_count, len, pick;

    // single-pixel blocks: empty sums, axis and sign cases
    push_pixel(0, 0, 1);          // both sums zero
    push_pixel(5, 5, 1);          // diff zero, cross positive
    push_pixel(5, -5, 1);         // diff zero, cross negative
    push_pixel(5, 0, 1);          // cross zero, diff positive
    push_pixel(0, 5, 1);          // cross zero, diff negative
    push_pixel(-1, 0, 1);
    // equal magnitudes: diagonal angles
    push_pixel(1, 1, 0);
    push_pixel(1, 0, 0);
    push_pixel(1, 0, 1);
    push_pixel(1, -1, 0);
    push_pixel(0, 1, 0);
    push_pixel(0, 1, 1);
    // field extremes, all within the 11-bit range
    push_pixel(-1024, -1024, 1);
    push_pixel(1023, -1024, 1);
    push_pixel(-1024, 1023, 1);
    push_pixel(1023, 1023, 0);
    push_pixel(-1023, 1020, 1);
    push_pixel(1023, 1, 1);
    push_pixel(3, 7, 1);
    push_pixel(-1020, -2, 1);

    // long block of mostly extreme pixels, large cross sum
    for (int i = 0; i < LONG_PIXELS; i++) begin
      if ($urandom_range(0, 7) == 0)
        push_pixel($urandom_range(0, 2047) - 1024, $urandom_range(0, 2047) - 1024,
                   i == LONG_PIXELS - 1);
      else
        push_pixel(-1024, -1024, i == LONG_PIXELS - 1);
    end

    // random blocks, mostly short so results come often
    random_count = 0;
    while (random_count < RANDOM_PIXELS) begin
      pick = $urandom_range(0, 99);
      if (pick < 80)      len = $urandom_range(1, 16);
      else if (pick < 95) len = $urandom_range(17, 64);
      else                len = $urandom_range(65, BLOCK_PIXELS);
      add_block(len, $urandom_range(0, 5));
      random_count += len;
    end

    // trailing pixels with no last mark: accumulate, no item out
    for (int i = 0; i < 5; i++)
      push_pixel($urandom_range(0, 2047) - 1024, $urandom_range(0, 2047) - 1024, 0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pixel_queue.size() > 0 || in_tvalid) @(posedge clk);
    while (orient_due.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    // anything still expected after settling is a failure
    mismatches += orient_due.size();
    if (mismatches == 0)
      $display("[block_gradient_orientation] OK");
    else
      $display("[block_gradient_orientation] ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("[block_gradient_orientation] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // driver: change inputs on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    pixel_t p;
    if (rst_n) begin
      cycle <= cycle + 1;
      if (!in_tvalid || in_taken) begin
        if (pixel_queue.size() > 0 && (calm || $urandom_range(0, 99) >= 21)) begin
          p = pixel_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {2'b00, p.gy, p.gx};
          in_tlast  <= p.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
      out_tready <= calm || ($urandom_range(0, 99) >= 21);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: sample handshakes on the rising edge, predict and check
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    in_taken <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      gx_now = longint'($signed(in_tdata[GRAD_W-1:0]));
      gy_now = longint'($signed(in_tdata[2*GRAD_W-1:GRAD_W]));
      diff_acc  = diff_acc + ACC_W'(gx_now * gx_now - gy_now * gy_now);
      cross_acc = cross_acc + ACC_W'(2 * gx_now * gy_now);
      if (in_tlast) begin
        orient_due.push_back(orientation_of(longint'(diff_acc), longint'(cross_acc)));
        diff_acc  = '0;
        cross_acc = '0;
      end
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (orient_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected orientation item %0d", out_tdata);
      end else begin
        if (out_tdata !== orient_due[0]) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("orientation_deg mismatch: expected %0d, got %0d",
                     orient_due[0], out_tdata);
        end
        void'(orient_due.pop_front());
      end
    end
  end

endmodule
